### rtl/cpdm_pkg.sv
package cpdm_pkg;

  // Width of the free-running capture counter (16 to 32)
  localparam int COUNT_WIDTH = 32;
  localparam int CW = COUNT_WIDTH;

  // Divider shift register width: widest quotient needed
  localparam int QW = (CW - 6 > 24) ? CW - 6 : 24;
  localparam int NW = $clog2(QW + 1);
  localparam int PW = CW + 14;

  // Quotient bit counts for each division
  localparam int FREQ_N  = 24;
  localparam int DUTY_N  = 15;
  localparam int ON_N    = CW - 6;
  localparam int FREQC_N = 17;
  localparam int DUTYC_N = 8;

  localparam logic [23:0] FREQ_NUM   = 24'd10000000;
  localparam logic [14:0] DUTY_MAX   = 15'd25599;
  localparam logic [13:0] DUTY_SCALE = 14'd10000;
  localparam logic [6:0]  DEC_DIV    = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPT,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_FREQ,
    OP_DUTY,
    OP_ONMS,
    OP_FREQ_C,
    OP_DUTY_C
  } op_t;

  typedef struct packed {
    logic          start;
    logic [CW-1:0] rem0;
    logic [QW-1:0] qr0;
    logic [CW-1:0] dv;
    logic [NW-1:0] n;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quo;
    logic [CW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] period;
    logic [CW-1:0] on_time;
  } cap_out_t;

endpackage

### rtl/cpdm_div.sv
module cpdm_div
  import cpdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [CW-1:0] rem;
  logic [QW-1:0] qr;
  logic [CW-1:0] dv;

  logic [CW:0] trial;
  logic [CW:0] diff;
  logic        ge;

  // Restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, qr[QW-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.n;
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem0;
      qr  <= req.qr0;
      dv  <= req.dv;
    end else if (busy) begin
      rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
      qr  <= {qr[QW-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = qr;
  assign rsp.rem  = rem;

endmodule

### rtl/cpdm_capture.sv
module cpdm_capture
  import cpdm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          kind,
  input  logic [CW-1:0] cap,
  input  logic [CW-1:0] top,
  output cap_out_t      co
);

  logic          ph1;
  logic          ph2;
  logic          done;
  logic          kind_r;
  logic [CW-1:0] cap_r;
  logic [CW-1:0] early;

  logic          pending;
  logic [CW-1:0] first_rise;
  logic [CW-1:0] second_rise;
  logic [CW-1:0] period;
  logic [CW-1:0] on_time;

  logic [CW-1:0] wrap_add;
  logic [CW-1:0] delta;

  // Difference modulo top + 1; the true value always fits below 2^CW
  assign wrap_add = (cap_r >= early) ? '0 : top + CW'(1);
  assign delta    = cap_r - early + wrap_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1         <= 1'b0;
      ph2         <= 1'b0;
      done        <= 1'b0;
      pending     <= 1'b0;
      first_rise  <= '0;
      second_rise <= '0;
      period      <= '0;
      on_time     <= '0;
    end else begin
      ph1  <= load;
      ph2  <= ph1;
      done <= ph2;
      if (ph2) begin
        if (!kind_r) begin
          if (!pending) begin
            first_rise <= cap_r;
            pending    <= 1'b1;
          end else begin
            second_rise <= cap_r;
            period      <= delta;
            pending     <= 1'b0;
          end
        end else begin
          on_time <= delta;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind;
      cap_r  <= cap;
    end else if (ph1) begin
      // Saturate to top and pick the rising capture to measure from
      cap_r <= (cap_r > top) ? top : cap_r;
      early <= (!kind_r || pending) ? first_rise : second_rise;
    end
  end

  assign co.done    = done;
  assign co.period  = period;
  assign co.on_time = on_time;

endmodule

### rtl/capture_period_duty_meter.sv
// Input-capture period and duty meter.
// Slave stream: one item per capture event; s_tuser is the edge kind
// (0 rising, 1 falling), s_tdata the counter value latched at the edge.
// Master stream: one item per event; m_tuser is high once a nonzero period
// has been measured, m_tdata holds frequency, on time and duty, each split
// into a whole part and truncated hundredths. With m_tuser low, m_tdata is 0.
// Config channel: cfg_data writes counter_top; write only while idle.
// Timing: one item at a time; s_tready is low from acceptance until the
// result is loaded into the output register, and the next item can be taken
// in the cycle after that. The result comes from a radix-2 divider, one
// quotient bit per cycle, used for five divisions in turn: 24 + 15 +
// (counter width - 6) + 17 + 8 bits. The duty division is skipped when duty
// saturates, and all divisions are skipped while the period is zero.
// Reset: clears edge state, period and on time, counter_top goes to all
// ones, output empty.
// Stall: a result waits in the output register while the next item is
// accepted and processed; a second result waits until the first is taken.
module capture_period_duty_meter
  import cpdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // capture_value
  input  logic [0:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // freq_whole, freq_hundredths, on_ms_whole, on_ms_hundredths,
  // duty_whole, duty_hundredths
  output logic [71:0] m_tdata,
  output logic [0:0]  m_tuser,   // valid_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // counter_top
);

  state_t state;
  state_t state_next;
  op_t    op;

  logic [CW-1:0] top_r;
  logic          load;
  logic          div_go;
  logic          ovf;
  logic          res_valid;

  cap_out_t co;
  div_req_t req;
  div_rsp_t rsp;

  logic [PW-1:0]   prod;
  logic [CW-2:0]   duty_hi;
  logic [23:0]     q;
  logic [14:0]     d;
  logic [16:0]     freq_whole;
  logic [6:0]      freq_h;
  logic [ON_N-1:0] on_whole;
  logic [6:0]      on_h;
  logic [7:0]      duty_w;
  logic [6:0]      duty_h;

  assign cfg_ready = 1'b1;
  assign load      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      top_r <= cfg_data[CW-1:0];
    end
  end

  cpdm_capture u_capture (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .kind (s_tuser[0]),
    .cap  (s_tdata[CW-1:0]),
    .top  (top_r),
    .co   (co)
  );

  cpdm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Duty quotient would reach 2^15 or more: saturate without dividing
  assign duty_hi = prod[PW-1:DUTY_N];
  assign ovf     = ({1'b0, duty_hi} >= co.period);

  always_comb begin
    req.start = div_go;
    req.rem0  = '0;
    req.qr0   = '0;
    req.dv    = co.period;
    req.n     = NW'(FREQ_N);
    case (op)
      OP_FREQ: begin
        req.qr0 = QW'(FREQ_NUM) << (QW - FREQ_N);
      end
      OP_DUTY: begin
        req.rem0 = CW'(duty_hi);
        req.qr0  = QW'(prod[DUTY_N-1:0]) << (QW - DUTY_N);
        req.n    = NW'(DUTY_N);
      end
      OP_ONMS: begin
        req.rem0 = CW'(co.on_time >> ON_N);
        req.qr0  = QW'(co.on_time[ON_N-1:0]) << (QW - ON_N);
        req.dv   = CW'(DEC_DIV);
        req.n    = NW'(ON_N);
      end
      OP_FREQ_C: begin
        req.rem0 = CW'(q >> FREQC_N);
        req.qr0  = QW'(q[FREQC_N-1:0]) << (QW - FREQC_N);
        req.dv   = CW'(DEC_DIV);
        req.n    = NW'(FREQC_N);
      end
      OP_DUTY_C: begin
        req.rem0 = CW'(d >> DUTYC_N);
        req.qr0  = QW'(d[DUTYC_N-1:0]) << (QW - DUTYC_N);
        req.dv   = CW'(DEC_DIV);
        req.n    = NW'(DUTYC_N);
      end
      default: begin
        req.rem0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CAPT;
        end
      end
      ST_CAPT: begin
        if (co.done) begin
          state_next = (co.period == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_START;
      end
      ST_START: begin
        if (!(op == OP_DUTY && ovf)) begin
          div_go     = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rsp.done) begin
          state_next = (op == OP_DUTY_C) ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Step through the divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_FREQ;
    end else if (state == ST_MUL) begin
      op <= OP_FREQ;
    end else if (state == ST_START && op == OP_DUTY && ovf) begin
      op <= OP_ONMS;
    end else if (state == ST_WAIT && rsp.done) begin
      case (op)
        OP_FREQ:   op <= OP_DUTY;
        OP_DUTY:   op <= OP_ONMS;
        OP_ONMS:   op <= OP_FREQ_C;
        OP_FREQ_C: op <= OP_DUTY_C;
        default:   op <= OP_FREQ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CAPT && co.done) begin
      res_valid <= (co.period != '0);
    end
    if (state == ST_MUL) begin
      prod <= co.on_time * DUTY_SCALE;
    end
    if (state == ST_START && op == OP_DUTY && ovf) begin
      d <= DUTY_MAX;
    end
    if (state == ST_WAIT && rsp.done) begin
      case (op)
        OP_FREQ: begin
          q <= rsp.quo[23:0];
        end
        OP_DUTY: begin
          d <= (rsp.quo[14:0] > DUTY_MAX) ? DUTY_MAX : rsp.quo[14:0];
        end
        OP_ONMS: begin
          on_whole <= rsp.quo[ON_N-1:0];
          on_h     <= rsp.rem[6:0];
        end
        OP_FREQ_C: begin
          freq_whole <= rsp.quo[16:0];
          freq_h     <= rsp.rem[6:0];
        end
        OP_DUTY_C: begin
          duty_w <= rsp.quo[7:0];
          duty_h <= rsp.rem[6:0];
        end
        default: begin
          q <= q;
        end
      endcase
    end
  end

  // Output register: load from the done state, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= res_valid;
      if (res_valid) begin
        m_tdata <= {duty_h, duty_w, on_h, 26'(on_whole), freq_h, freq_whole};
      end else begin
        m_tdata <= '0;
      end
    end
  end

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !rsp.busy)
    else $error("divider busy when a new item is accepted");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == ST_WAIT))
    else $error("divider finished outside the wait state");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("result without period carries nonzero data");

  a_hundredths: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:17] < 7'd100 && m_tdata[56:50] < 7'd100 &&
                  m_tdata[71:65] < 7'd100))
    else $error("hundredths field out of range");
`endif

endmodule
